### rtl/env_map_importance_cdf_defines.svh
// Assertion macros for the environment map importance CDF block.
`ifndef ENV_MAP_IMPORTANCE_CDF_DEFINES_SVH
`define ENV_MAP_IMPORTANCE_CDF_DEFINES_SVH
// Property that must hold at every clock edge outside reset.
`define EMIC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication whose consequent is checked in the following cycle.
`define EMIC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

### rtl/emic_pkg.sv
// Package of the environment map importance CDF block: constants and table functions.
package emic_pkg;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_SINE_DEPTH = 1024;
  localparam int ROW_SUM_W = 42;
  localparam int TOTAL_W = 51;
  localparam int CDF_W = 25;
  localparam int FRAC_BITS = 24;
  localparam logic [CDF_W-1:0] ONE_Q24 = 25'd16777216;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_RD_COND = 2'd1;
  localparam logic [1:0] CMD_RD_MARG = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_LOADED = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Unsigned quotient by shift and subtract, evaluated at elaboration only.
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Sine table entry, evaluated at elaboration only.
  function automatic logic [15:0] sine_entry(input int unsigned i, input int unsigned depth);
    longint unsigned j, x, t, s;
    j = i;
    if (2 * i + 1 > depth) j = depth - 1 - i;
    x = udiv(64'd3373259426 * (2 * j + 1), 2 * longint'(depth));
    t = x;
    s = x;
    for (int k = 1; k <= 5; k++) begin
      t = (((t * x) >> 30) * x) >> 30;
      t = udiv(t, (2 * k) * (2 * k + 1));
      if ((k & 1) == 1) s = s - t;
      else s = s + t;
    end
    s = (s + 8192) >> 14;
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction
endpackage

### rtl/emic_div.sv
// Radix-2 restoring divider: 24-bit fraction of prefix/sum, one bit per cycle.
module emic_div import emic_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TOTAL_W-1:0] num,
  input  logic [TOTAL_W-1:0] den,
  output logic               done,
  output logic [CDF_W-1:0]   quo
);
  logic [TOTAL_W:0] rem_r, rem_nxt;
  logic [TOTAL_W-1:0] den_r;
  logic [CDF_W-1:0] quo_r, quo_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [TOTAL_W:0] sh;

  assign sh = {rem_r[TOTAL_W-1:0], 1'b0};

  always_comb begin
    rem_nxt = rem_r; quo_nxt = quo_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      rem_nxt = {1'b0, num};
      cnt_nxt = 5'd0;
      if (den == '0) begin
        quo_nxt = '0; done_nxt = 1'b1; busy_nxt = 1'b0;
      end else if (num >= den) begin
        quo_nxt = ONE_Q24; done_nxt = 1'b1; busy_nxt = 1'b0;
      end else begin
        quo_nxt = '0; busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        quo_nxt = {quo_r[CDF_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        quo_nxt = {quo_r[CDF_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(FRAC_BITS - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo = quo_r;
endmodule

### rtl/env_map_importance_cdf.sv
// Top level of the environment map importance CDF block.
// Builds 2D importance-sampling CDF tables from an HDR equirectangular map and
// answers CDF reads. One item is in flight at a time. A pixel push passes
// through luminance (three 32x16 products), row sine weight, then the prefix
// and row memory writes. The first pixel of a row first passes through a sine
// index state ahead of that, where the sine table index floor((2y+1)*D/(2h))
// is found one quotient bit per cycle. A read passes through the memory read,
// a divider start, the 24-step one-bit-a-cycle divider and its done flag
// before it raises out_valid. A zero or saturating sum skips the divider's
// bit steps; a last entry or an error status raises out_valid straight from
// the read state. Restart and ignored pushes stay in idle. Prefix memory
// holds 2^(CW+RW) entries of 42 bits (MAX_WIDTH*MAX_HEIGHT at the default
// sizes), the row sum and marginal memories MAX_HEIGHT entries; none is
// cleared after reset. Output is a registered beat; the next item is taken
// once it is accepted.
`include "env_map_importance_cdf_defines.svh"
module env_map_importance_cdf import emic_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [31:0]       in_red,
  input  logic [31:0]       in_green,
  input  logic [31:0]       in_blue,
  input  logic [8:0]        in_read_row,
  input  logic [9:0]        in_read_column,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CDF_W-1:0]  out_cdf_value,
  output logic [1:0]        out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [10:0]       cfg_data
);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SW = $clog2(SINE_TABLE_DEPTH);
  localparam int SCW = $clog2(SW + 1);
  localparam int PW = CW + RW;
  localparam int PD = 1 << PW;

  localparam logic [2:0] S_IDLE = 3'd0, S_LUM = 3'd1, S_IMP = 3'd2, S_ACC = 3'd3,
                         S_RD = 3'd4, S_DIV = 3'd5, S_OUT = 3'd6, S_SIX = 3'd7;

  typedef logic [15:0] sine_tab_t [SINE_TABLE_DEPTH];
  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) t[i] = sine_entry(i, SINE_TABLE_DEPTH);
    return t;
  endfunction
  localparam sine_tab_t SINE = build_sine();

  // Memories.
  logic [ROW_SUM_W-1:0] prefix_mem [PD];
  logic [ROW_SUM_W-1:0] rowsum_mem [MAX_HEIGHT];
  logic [TOTAL_W-1:0]   marg_mem [MAX_HEIGHT];
  logic [ROW_SUM_W-1:0] prefix_q, rowsum_q;
  logic [TOTAL_W-1:0]   marg_q, marg_last_q;

  logic [2:0] state_r;
  logic [10:0] width_r;
  logic [9:0]  height_r;
  logic [1:0] cmd_r;
  logic [31:0] red_r, green_r, blue_r;
  logic [8:0] rrow_r;
  logic [9:0] rcol_r;
  logic [ROW_SUM_W-1:0] run_row_r;
  logic [TOTAL_W-1:0] run_tot_r;
  logic [CW-1:0] pcol_r;
  logic [RW-1:0] prow_r;
  logic [15:0] weight_r;
  logic loaded_r;
  logic [49:0] lum_r;
  logic [ROW_SUM_W-1:0] imp_r;
  logic [CDF_W-1:0] cdf_r;
  logic [1:0] status_r;
  logic out_valid_r;

  // Effective sizes.
  logic [12:0] eff_w;
  logic [11:0] eff_h;
  always_comb begin
    if (width_r == '0) eff_w = 13'd1;
    else if (13'(width_r) > 13'(MAX_WIDTH)) eff_w = 13'(MAX_WIDTH);
    else eff_w = 13'(width_r);
    if (height_r == '0) eff_h = 12'd1;
    else if (12'(height_r) > 12'(MAX_HEIGHT)) eff_h = 12'(MAX_HEIGHT);
    else eff_h = 12'(height_r);
  end

  // Sine index for the row: floor((2y+1)*D/(2h)), one quotient bit per cycle
  // at row start; a quotient at or above the table depth is clamped.
  logic [31:0] six_num, six_den0, six_rem_r, six_den_r;
  logic [SCW-1:0] six_cnt_r;
  logic [SW:0] sidx_r, sidx_cl;
  assign six_num = 32'((2 * 32'(prow_r) + 1) * SINE_TABLE_DEPTH);
  assign six_den0 = 32'(eff_h) << (SW + 1);
  assign sidx_cl = (sidx_r >= (SW+1)'(SINE_TABLE_DEPTH)) ? (SW+1)'(SINE_TABLE_DEPTH - 1)
                                                         : sidx_r;

  logic [CW-1:0] rcol_idx;
  logic [RW-1:0] rrow_idx, hlast_idx;
  assign rcol_idx = CW'(rcol_r);
  assign rrow_idx = RW'(rrow_r);
  assign hlast_idx = RW'(eff_h - 12'd1);

  logic wr_en;
  logic row_end;
  logic [ROW_SUM_W-1:0] new_row;
  logic [TOTAL_W-1:0] new_tot;
  assign new_row = run_row_r + imp_r;
  assign new_tot = run_tot_r + TOTAL_W'(new_row);
  assign row_end = (13'(pcol_r) + 13'd1 >= eff_w);
  assign wr_en = (state_r == S_ACC) && !loaded_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prefix_mem[PW'({prow_r, pcol_r})] <= new_row;
      if (row_end) begin
        rowsum_mem[prow_r] <= new_row;
        marg_mem[prow_r] <= new_tot;
      end
    end
    if (state_r == S_RD) begin
      prefix_q <= prefix_mem[PW'({rrow_idx, rcol_idx})];
      rowsum_q <= rowsum_mem[rrow_idx];
      marg_q <= marg_mem[rrow_idx];
      marg_last_q <= marg_mem[hlast_idx];
    end
  end

  logic div_start, div_done;
  logic [CDF_W-1:0] div_q;
  logic [TOTAL_W-1:0] div_num, div_den;
  assign div_num = (cmd_r == CMD_RD_COND) ? TOTAL_W'(prefix_q) : marg_q;
  assign div_den = (cmd_r == CMD_RD_COND) ? TOTAL_W'(rowsum_q) : marg_last_q;

  emic_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  logic in_fire, out_fire;
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;

  logic rd_err, rd_last;
  always_comb begin
    rd_err = (12'(rrow_r) >= eff_h) || (cmd_r == CMD_RD_COND && 13'(rcol_r) >= eff_w);
    rd_last = (cmd_r == CMD_RD_COND) ? (13'(rcol_r) == eff_w - 13'd1)
                                     : (12'(rrow_r) == eff_h - 12'd1);
  end

  logic div_busy_r;
  assign div_start = (state_r == S_DIV) && !div_busy_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_command; red_r <= in_red; green_r <= in_green; blue_r <= in_blue;
      rrow_r <= in_read_row; rcol_r <= in_read_column;
    end
    // Luminance: three 32x16 products, fixed coefficients.
    if (state_r == S_LUM)
      lum_r <= 50'((50'(red_r) * 50'd13933 + 50'(green_r) * 50'd46871
                    + 50'(blue_r) * 50'd4732) >> 16);
    if (state_r == S_IMP)
      imp_r <= ROW_SUM_W'((lum_r[33:0] * 50'(weight_r)) >> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; width_r <= 11'd1024; height_r <= 10'd512;
      run_row_r <= '0; run_tot_r <= '0; pcol_r <= '0; prow_r <= '0;
      weight_r <= '0; loaded_r <= 1'b0; out_valid_r <= 1'b0; div_busy_r <= 1'b0;
      cdf_r <= '0; status_r <= ST_OK;
      six_rem_r <= '0; six_den_r <= '0; six_cnt_r <= '0; sidx_r <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_WIDTH) width_r <= cfg_data;
        else height_r <= cfg_data[9:0];
      end
      if (out_fire) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          unique case (in_command)
            CMD_PUSH: begin
              if (loaded_r) state_r <= S_IDLE;
              else if (pcol_r == '0) begin
                six_rem_r <= six_num; six_den_r <= six_den0;
                six_cnt_r <= SCW'(SW); sidx_r <= '0;
                state_r <= S_SIX;
              end else state_r <= S_LUM;
            end
            CMD_RESTART: begin
              run_row_r <= '0; run_tot_r <= '0; pcol_r <= '0; prow_r <= '0;
              weight_r <= '0; loaded_r <= 1'b0;
            end
            default: state_r <= S_RD;
          endcase
        end
        S_SIX: begin
          if (six_rem_r >= six_den_r) begin
            six_rem_r <= six_rem_r - six_den_r;
            sidx_r <= {sidx_r[SW-1:0], 1'b1};
          end else sidx_r <= {sidx_r[SW-1:0], 1'b0};
          six_den_r <= six_den_r >> 1;
          six_cnt_r <= six_cnt_r - SCW'(1);
          if (six_cnt_r == '0) state_r <= S_LUM;
        end
        S_LUM: begin
          if (pcol_r == '0) weight_r <= SINE[SW'(sidx_cl)];
          state_r <= S_IMP;
        end
        S_IMP: state_r <= S_ACC;
        S_ACC: begin
          state_r <= S_IDLE;
          if (row_end) begin
            run_tot_r <= new_tot; run_row_r <= '0; pcol_r <= '0;
            if (12'(prow_r) + 12'd1 >= eff_h) loaded_r <= 1'b1;
            else prow_r <= prow_r + RW'(1);
          end else begin
            run_row_r <= new_row; pcol_r <= pcol_r + CW'(1);
          end
        end
        S_RD: begin
          if (!loaded_r || rd_err || rd_last) begin
            status_r <= !loaded_r ? ST_NOT_LOADED : (rd_err ? ST_RANGE : ST_OK);
            cdf_r <= (loaded_r && !rd_err) ? ONE_Q24 : '0;
            out_valid_r <= 1'b1;
            state_r <= S_OUT;
          end else state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done && div_busy_r) begin
            div_busy_r <= 1'b0; cdf_r <= div_q; status_r <= ST_OK;
            out_valid_r <= 1'b1; state_r <= S_OUT;
          end else div_busy_r <= 1'b1;
        end
        S_OUT: if (out_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_cdf_value = cdf_r;
  assign out_status = status_r;

  `EMIC_ASSERT(a_ready_idle, !(in_ready && out_valid_r), "input taken while result pending")
  `EMIC_ASSERT(a_cdf_range, !out_valid_r || (cdf_r <= ONE_Q24), "cdf above one")
  `EMIC_ASSERT(a_err_zero, !out_valid_r || status_r == ST_OK || cdf_r == '0, "error beat nonzero")
  `EMIC_ASSERT_NEXT(a_no_write_loaded, wr_en, state_r == S_IDLE, "push did not retire")
endmodule
